// ===== src/sha1bc_pkg.sv =====
// Package for the SHA-1 block compression engine.
// Holds payload and queue types, SHA-1 constants and round helpers; no dependencies.
`timescale 1ns / 1ps

package sha1bc_pkg;

  // Incoming message word
  typedef struct packed {
    logic [31:0] message_word;
    logic        restart;
  } sha1bc_in_t;

  // Outgoing digest word
  typedef struct packed {
    logic [31:0] digest_word;
    logic        last_word;
  } sha1bc_out_t;

  // Classified word as it travels through the queue
  typedef struct packed {
    logic [31:0] word;
    logic        restart;
    logic        last;
  } sha1bc_qitem_t;

  // Queue status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } sha1bc_qstat_t;

  localparam int unsigned NumChain  = 5;
  localparam int unsigned NumRounds = 80;
  localparam int unsigned WinDepth  = 16;

  localparam logic [31:0] IV [NumChain] = '{
    32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0
  };

  localparam logic [31:0] K0 = 32'h5a827999;
  localparam logic [31:0] K1 = 32'h6ed9eba1;
  localparam logic [31:0] K2 = 32'h8f1bbcdc;
  localparam logic [31:0] K3 = 32'hca62c1d6;

  localparam logic [3:0] LastWordIdx = 4'd15;

  // Round function: Ch, Parity, Maj, Parity by round range
  function automatic logic [31:0] sha1bc_f(input logic [6:0] t, input logic [31:0] b,
                                           input logic [31:0] c, input logic [31:0] d);
    logic [31:0] r;
    if (t < 7'd20) begin
      r = (b & c) | (~b & d);
    end else if (t >= 7'd40 && t < 7'd60) begin
      r = (b & c) | (b & d) | (c & d);
    end else begin
      r = b ^ c ^ d;
    end
    return r;
  endfunction

  // Round constant by round range
  function automatic logic [31:0] sha1bc_k(input logic [6:0] t);
    logic [31:0] r;
    if (t < 7'd20) begin
      r = K0;
    end else if (t < 7'd40) begin
      r = K1;
    end else if (t < 7'd60) begin
      r = K2;
    end else begin
      r = K3;
    end
    return r;
  endfunction

endpackage

// ===== src/sha1bc_front.sv =====
// Front end: accepts message words, tracks position in the block, tags restart/last.
// Depends on sha1bc_pkg.
`timescale 1ns / 1ps

module sha1bc_front import sha1bc_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  sha1bc_in_t    in_data_i,
  input  sha1bc_qstat_t qstat_i,
  output logic          push_o,
  output sha1bc_qitem_t push_item_o
);

  logic [3:0] word_count_q, word_count_d;
  logic [3:0] idx;

  assign in_stall_o = qstat_i.full;
  assign push_o     = in_valid_i && !qstat_i.full;

  // restart drops any partial block: this word becomes word 0
  assign idx = in_data_i.restart ? 4'd0 : word_count_q;

  assign push_item_o.word    = in_data_i.message_word;
  assign push_item_o.restart = in_data_i.restart;
  assign push_item_o.last    = (idx == LastWordIdx);

  always_comb begin
    word_count_d = word_count_q;
    if (push_o) begin
      word_count_d = (idx == LastWordIdx) ? 4'd0 : idx + 4'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_count_q <= 4'd0;
    end else begin
      word_count_q <= word_count_d;
    end
  end

endmodule

// ===== src/sha1bc_fifo.sv =====
// Short word queue between front end and compression back end.
// Depends on sha1bc_pkg.
`timescale 1ns / 1ps

module sha1bc_fifo import sha1bc_pkg::*; #(
  parameter int unsigned Depth = 4
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  sha1bc_qitem_t push_item_i,
  input  logic          pop_i,
  output sha1bc_qitem_t pop_item_o,
  output sha1bc_qstat_t qstat_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  sha1bc_qitem_t   mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_push, do_pop;

  assign qstat_o.full  = (count_q == CntW'(Depth));
  assign qstat_o.empty = (count_q == '0);
  assign do_push       = push_i && !qstat_o.full;
  assign do_pop        = pop_i && !qstat_o.empty;
  assign pop_item_o    = mem_q[rd_ptr_q];

  function automatic logic [PtrW-1:0] next_ptr(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) wr_ptr_q <= next_ptr(wr_ptr_q);
      if (do_pop)  rd_ptr_q <= next_ptr(rd_ptr_q);
      if (do_push && !do_pop) begin
        count_q <= count_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

endmodule

// ===== src/sha1bc_core.sv =====
// Back end: fills the schedule window, runs 80 rounds, adds into the chain, emits digest.
// Depends on sha1bc_pkg.
`timescale 1ns / 1ps

module sha1bc_core import sha1bc_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  sha1bc_qitem_t pop_item_i,
  input  sha1bc_qstat_t qstat_i,
  output logic          pop_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output sha1bc_out_t   out_data_o
);

  typedef enum logic [3:0] {
    ST_LOAD  = 4'b0001,
    ST_ROUND = 4'b0010,
    ST_ADD   = 4'b0100,
    ST_OUT   = 4'b1000
  } state_e;

  state_e      state_q, state_d;
  logic [6:0]  round_q;
  logic [2:0]  out_idx_q;
  logic [31:0] chain_q [NumChain];
  logic [31:0] win_q [WinDepth];
  logic [31:0] a_q, b_q, c_q, d_q, e_q;
  logic        out_valid_q;
  sha1bc_out_t out_data_q;

  logic [31:0] wt, tmp, expand;
  logic        out_load;

  assign pop_o       = (state_q == ST_LOAD) && !qstat_i.empty;
  assign out_load    = (state_q == ST_OUT) && (!out_valid_q || !out_stall_i);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // message schedule: window is a shift line, oldest word at index 0
  assign expand = win_q[13] ^ win_q[8] ^ win_q[2] ^ win_q[0];
  assign wt     = (round_q < 7'd16) ? win_q[0] : {expand[30:0], expand[31]};
  assign tmp    = {a_q[26:0], a_q[31:27]} + sha1bc_f(round_q, b_q, c_q, d_q) + e_q + wt
                + sha1bc_k(round_q);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_LOAD:  if (pop_o && pop_item_i.last) state_d = ST_ROUND;
      ST_ROUND: if (round_q == 7'(NumRounds - 1)) state_d = ST_ADD;
      ST_ADD:   state_d = ST_OUT;
      ST_OUT:   if (out_load && out_idx_q == 3'(NumChain - 1)) state_d = ST_LOAD;
      default:  state_d = ST_LOAD;
    endcase
  end

  // control, chaining value and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      round_q     <= '0;
      out_idx_q   <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NumChain; i++) chain_q[i] <= IV[i];
    end else begin
      state_q <= state_d;
      if (pop_o && pop_item_i.restart) begin
        for (int i = 0; i < NumChain; i++) chain_q[i] <= IV[i];
      end
      if (state_q == ST_ROUND) round_q <= round_q + 7'd1;
      else                     round_q <= '0;
      if (state_q == ST_ADD) begin
        chain_q[0] <= chain_q[0] + a_q;
        chain_q[1] <= chain_q[1] + b_q;
        chain_q[2] <= chain_q[2] + c_q;
        chain_q[3] <= chain_q[3] + d_q;
        chain_q[4] <= chain_q[4] + e_q;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
        out_idx_q   <= (out_idx_q == 3'(NumChain - 1)) ? 3'd0 : out_idx_q + 3'd1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      for (int i = 0; i < WinDepth - 1; i++) win_q[i] <= win_q[i+1];
      win_q[WinDepth-1] <= pop_item_i.word;
      if (pop_item_i.last) begin
        a_q <= chain_q[0];
        b_q <= chain_q[1];
        c_q <= chain_q[2];
        d_q <= chain_q[3];
        e_q <= chain_q[4];
      end
    end
    if (state_q == ST_ROUND) begin
      for (int i = 0; i < WinDepth - 1; i++) win_q[i] <= win_q[i+1];
      win_q[WinDepth-1] <= wt;
      e_q <= d_q;
      d_q <= c_q;
      c_q <= {b_q[1:0], b_q[31:2]};
      b_q <= a_q;
      a_q <= tmp;
    end
    if (out_load) begin
      out_data_q.digest_word <= chain_q[out_idx_q];
      out_data_q.last_word   <= (out_idx_q == 3'(NumChain - 1));
    end
  end

  // checks
  a_round_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ROUND) |-> (round_q < 7'(NumRounds)))
    else $error("round counter out of range");

  a_round_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ROUND && round_q == 7'(NumRounds - 1)) |=> (state_q == ST_ADD))
    else $error("rounds did not finish into chain add");

  a_add_then_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ADD) |=> (state_q == ST_OUT && out_idx_q == 3'd0))
    else $error("chain add not followed by digest output from H0");

  a_last_marked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && out_idx_q == 3'(NumChain - 1)) |=>
    (out_valid_o && out_data_o.last_word && state_q == ST_LOAD))
    else $error("fifth digest word not marked last");

endmodule

// ===== src/sha1_block_compression.sv =====
// Top level of the SHA-1 block compression engine.
// Depends on sha1bc_pkg, sha1bc_front, sha1bc_fifo and sha1bc_core.
//
//   channel | ports                              | moves
//   --------+------------------------------------+-------------------------------
//   in      | in_valid_i, in_stall_o, in_data_i  | one message word (+ restart)
//   out     | out_valid_o, out_stall_i, out_data_o | one digest word (+ last flag)
//
// A block takes 16 queue pops, then 80 rounds in the single round datapath, one chain
// add and five digest words.
// The front keeps taking words into the queue while rounds run, up to QDepth.
// Reset loads the initial chain value; no clearing pass is needed.
// Output stall holds the digest register and pauses the back end only.
`timescale 1ns / 1ps

module sha1_block_compression import sha1bc_pkg::*; #(
  parameter int unsigned QDepth = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  sha1bc_in_t  in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output sha1bc_out_t out_data_o
);

  sha1bc_qstat_t qstat;
  sha1bc_qitem_t push_item, pop_item;
  logic          push, pop;

  sha1bc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .qstat_i     (qstat),
    .push_o      (push),
    .push_item_o (push_item)
  );

  sha1bc_fifo #(
    .Depth (QDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .pop_i       (pop),
    .pop_item_o  (pop_item),
    .qstat_o     (qstat)
  );

  sha1bc_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_item_i  (pop_item),
    .qstat_i     (qstat),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
